[sv/sbpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpd_pkg
// Shared types and constants for the seven-bit packet deframer.
// ----------------------------------------------------------------------------
package sbpd_pkg;

    localparam int ERROR_COUNT_BITS = 16;
    localparam int ERR_TOTAL_W      = 16;
    localparam int DATA_LEN         = 7;
    localparam int IDX_W            = $clog2(DATA_LEN);
    localparam int BYTE_W           = 8;
    localparam int ID_LIMIT_W       = 9;
    localparam logic [ID_LIMIT_W-1:0] MAX_PACK_ID_RESET = 9'd128;

    typedef enum logic [1:0] {
        EV_GOOD     = 2'd0,
        EV_CHECKSUM = 2'd1,
        EV_NON_DATA = 2'd2,
        EV_BAD_ID   = 2'd3
    } event_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_HEADER = 4'b0010,
        ST_DATA   = 4'b0100,
        ST_CHECK  = 4'b1000
    } state_t;

    typedef struct packed {
        event_t                                  kind;
        logic [BYTE_W-1:0]                       pack_id;
        logic [DATA_LEN-1:0][BYTE_W-1:0]         data;
        logic [ERR_TOTAL_W-1:0]                  error_total;
    } result_t;

endpackage

[sv/seven_bit_packet_deframer_core.sv]
`timescale 1ns / 1ps
// An accepted input word passes through the input register, then the result register, to result valid.
// Throughput: one input word per cycle while the result register is not stalled by m_ready.
// Input words that end no packet and raise no error produce no result.
// Reset (aresetn low, synchronous) idles the framer, clears the error count
// and sets max_pack_id to 128.
// ----------------------------------------------------------------------------
// seven_bit_packet_deframer_core
// Deframes 7-bit flagged packets: ID, header, seven data bytes, checksum.
// ----------------------------------------------------------------------------
module seven_bit_packet_deframer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sbpd_pkg::ID_LIMIT_W-1:0]     cfg_max_pack_id,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sbpd_pkg::BYTE_W-1:0]         s_rx_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_event_kind,
    output logic [sbpd_pkg::BYTE_W-1:0]         m_pack_id,
    output logic [sbpd_pkg::BYTE_W-1:0]         m_data_0,
    output logic [sbpd_pkg::BYTE_W-1:0]         m_data_1,
    output logic [sbpd_pkg::BYTE_W-1:0]         m_data_2,
    output logic [sbpd_pkg::BYTE_W-1:0]         m_data_3,
    output logic [sbpd_pkg::BYTE_W-1:0]         m_data_4,
    output logic [sbpd_pkg::BYTE_W-1:0]         m_data_5,
    output logic [sbpd_pkg::BYTE_W-1:0]         m_data_6,
    output logic [sbpd_pkg::ERR_TOTAL_W-1:0]    m_error_total
);

    logic                        in_valid;
    logic [sbpd_pkg::BYTE_W-1:0] in_byte;
    logic                        out_ready;
    logic                        fire;
    logic                        res_valid;
    sbpd_pkg::result_t           res;
    sbpd_pkg::result_t           m_res;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid && out_ready;

    sbpd_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .take      (out_ready),
        .in_valid  (in_valid),
        .in_byte   (in_byte)
    );

    sbpd_framer u_framer (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_max_pack_id (cfg_max_pack_id),
        .fire            (fire),
        .in_byte         (in_byte),
        .res_valid       (res_valid),
        .res             (res)
    );

    sbpd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire && res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_event_kind  = m_res.kind;
    assign m_pack_id     = m_res.pack_id;
    assign m_data_0      = m_res.data[0];
    assign m_data_1      = m_res.data[1];
    assign m_data_2      = m_res.data[2];
    assign m_data_3      = m_res.data[3];
    assign m_data_4      = m_res.data[4];
    assign m_data_5      = m_res.data[5];
    assign m_data_6      = m_res.data[6];
    assign m_error_total = m_res.error_total;

endmodule

[sv/sbpd_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpd_in_stage
// Input word register; refills in the same cycle it is consumed.
// ----------------------------------------------------------------------------
module sbpd_in_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sbpd_pkg::BYTE_W-1:0] s_rx_byte,
    input  logic                        take,
    output logic                        in_valid,
    output logic [sbpd_pkg::BYTE_W-1:0] in_byte
);

    logic                        valid_reg, valid_next;
    logic [sbpd_pkg::BYTE_W-1:0] byte_reg, byte_next;

    assign s_ready  = !valid_reg || take;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (s_ready) begin
            valid_next = s_valid;
            byte_next  = s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
    end

endmodule

[sv/sbpd_framer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpd_framer
// Packet state machine, checksum, data store, error count and ID limit.
// ----------------------------------------------------------------------------
module sbpd_framer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [sbpd_pkg::ID_LIMIT_W-1:0] cfg_max_pack_id,
    input  logic                            fire,
    input  logic [sbpd_pkg::BYTE_W-1:0]     in_byte,
    output logic                            res_valid,
    output sbpd_pkg::result_t               res
);

    sbpd_pkg::state_t                        state_reg, state_next;
    logic [sbpd_pkg::IDX_W-1:0]              idx_reg, idx_next;
    logic [sbpd_pkg::BYTE_W-1:0]             id_reg, id_next;
    logic [sbpd_pkg::BYTE_W-1:0]             header_reg, header_next;
    logic [6:0]                              sum_reg, sum_next;
    logic [6:0]                              raw_reg  [sbpd_pkg::DATA_LEN];
    logic [6:0]                              raw_next [sbpd_pkg::DATA_LEN];
    logic [sbpd_pkg::ERROR_COUNT_BITS-1:0]   err_reg, err_next;
    logic [sbpd_pkg::ID_LIMIT_W-1:0]         max_id_reg, max_id_next;
    logic                                    err_hit;
    logic [sbpd_pkg::DATA_LEN-1:0][sbpd_pkg::BYTE_W-1:0] decoded;

    always_comb begin
        for (int k = 0; k < sbpd_pkg::DATA_LEN; k++) begin
            decoded[k] = {header_reg[k], raw_reg[k]};
        end
    end

    assign max_id_next = cfg_valid ? cfg_max_pack_id : max_id_reg;
    assign err_next    = err_reg + sbpd_pkg::ERROR_COUNT_BITS'(err_hit);

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        id_next     = id_reg;
        header_next = header_reg;
        sum_next    = sum_reg;
        for (int k = 0; k < sbpd_pkg::DATA_LEN; k++) begin
            raw_next[k] = raw_reg[k];
        end
        err_hit         = 1'b0;
        res_valid       = 1'b0;
        res.kind        = sbpd_pkg::EV_GOOD;
        res.pack_id     = id_reg;
        res.data        = '0;
        res.error_total = '0;

        if (fire) begin
            priority if (state_reg == sbpd_pkg::ST_IDLE) begin
                if ({1'b0, in_byte} < max_id_reg) begin
                    state_next = sbpd_pkg::ST_HEADER;
                    id_next    = in_byte;
                    sum_next   = in_byte[6:0];
                end else begin
                    err_hit     = 1'b1;
                    res_valid   = 1'b1;
                    res.kind    = sbpd_pkg::EV_BAD_ID;
                    res.pack_id = in_byte;
                end
            end else if (!in_byte[7]) begin
                // stray byte: drop it and abort the packet
                state_next = sbpd_pkg::ST_IDLE;
                err_hit    = 1'b1;
                res_valid  = 1'b1;
                res.kind   = sbpd_pkg::EV_NON_DATA;
            end else begin
                unique case (state_reg)
                    sbpd_pkg::ST_HEADER: begin
                        header_next = in_byte;
                        sum_next    = sum_reg + in_byte[6:0];
                        idx_next    = '0;
                        state_next  = sbpd_pkg::ST_DATA;
                    end
                    sbpd_pkg::ST_DATA: begin
                        raw_next[idx_reg] = in_byte[6:0];
                        sum_next          = sum_reg + in_byte[6:0];
                        if (idx_reg == sbpd_pkg::IDX_W'(sbpd_pkg::DATA_LEN - 1)) begin
                            state_next = sbpd_pkg::ST_CHECK;
                        end else begin
                            idx_next = idx_reg + sbpd_pkg::IDX_W'(1);
                        end
                    end
                    sbpd_pkg::ST_CHECK: begin
                        state_next = sbpd_pkg::ST_IDLE;
                        res_valid  = 1'b1;
                        res.data   = decoded;
                        if (sum_reg == in_byte[6:0]) begin
                            res.kind = sbpd_pkg::EV_GOOD;
                        end else begin
                            res.kind = sbpd_pkg::EV_CHECKSUM;
                            err_hit  = 1'b1;
                        end
                    end
                    default: begin
                        state_next = sbpd_pkg::ST_IDLE;
                    end
                endcase
            end
        end
        res.error_total = sbpd_pkg::ERR_TOTAL_W'(err_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sbpd_pkg::ST_IDLE;
            idx_reg    <= '0;
            err_reg    <= '0;
            max_id_reg <= sbpd_pkg::MAX_PACK_ID_RESET;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            err_reg    <= err_next;
            max_id_reg <= max_id_next;
        end
        id_reg     <= id_next;
        header_reg <= header_next;
        sum_reg    <= sum_next;
        for (int k = 0; k < sbpd_pkg::DATA_LEN; k++) begin
            raw_reg[k] <= raw_next[k];
        end
    end

endmodule

[sv/sbpd_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpd_out_stage
// Result word register toward the downstream side.
// ----------------------------------------------------------------------------
module sbpd_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  sbpd_pkg::result_t res,
    output logic              out_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output sbpd_pkg::result_t m_res
);

    logic              valid_reg, valid_next;
    sbpd_pkg::result_t res_reg, res_next;

    assign out_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_res     = res_reg;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (out_ready) begin
            valid_next = load;
            if (load) begin
                res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

endmodule

[sv/sbpd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpd_checker
// Port-level checks for the deframer core, bound to the top level.
// ----------------------------------------------------------------------------
module sbpd_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [1:0]                       m_event_kind,
    input logic [sbpd_pkg::BYTE_W-1:0]      m_pack_id,
    input logic [sbpd_pkg::BYTE_W-1:0]      m_data_0,
    input logic [sbpd_pkg::BYTE_W-1:0]      m_data_6,
    input logic [sbpd_pkg::ERR_TOTAL_W-1:0] m_error_total
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind)
            && $stable(m_pack_id) && $stable(m_error_total))
        else $error("result word changed while stalled");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result word without an input word two cycles earlier");

    a_abort_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind == sbpd_pkg::EV_NON_DATA
            || m_event_kind == sbpd_pkg::EV_BAD_ID)
        |-> m_data_0 == '0 && m_data_6 == '0)
        else $error("data present on an aborted or rejected word");

    a_good_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready ##1 m_valid && m_event_kind == sbpd_pkg::EV_GOOD
        |-> m_error_total == $past(m_error_total))
        else $error("error count moved on a good packet");

endmodule

bind seven_bit_packet_deframer_core sbpd_checker u_sbpd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_event_kind  (m_event_kind),
    .m_pack_id     (m_pack_id),
    .m_data_0      (m_data_0),
    .m_data_6      (m_data_6),
    .m_error_total (m_error_total)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the seven-bit packet deframer. Streams well-formed,
// corrupted and aborted packets plus noise words under several ID limits,
// with random gaps and result stalls. A scoreboard predicts every event and
// compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_WORDS  = 85;

    class deframer_scoreboard;
        logic [sbpd_pkg::ID_LIMIT_W-1:0]  id_limit;
        bit                               framing;
        int                               tail_pos;
        logic [sbpd_pkg::BYTE_W-1:0]      id_byte;
        logic [sbpd_pkg::BYTE_W-1:0]      header_byte;
        logic [sbpd_pkg::BYTE_W-1:0]      raw [sbpd_pkg::DATA_LEN];
        logic [6:0]                       sum;
        logic [sbpd_pkg::ERR_TOTAL_W-1:0] err_count;
        sbpd_pkg::result_t                expected_q[$];
        int                               mismatches;
        int                               kind_total[4];

        function new();
            id_limit    = sbpd_pkg::MAX_PACK_ID_RESET;
            framing     = 1'b0;
            tail_pos    = 0;
            id_byte     = '0;
            header_byte = '0;
            sum         = '0;
            err_count   = '0;
            mismatches  = 0;
            for (int k = 0; k < sbpd_pkg::DATA_LEN; k++) raw[k] = '0;
            for (int k = 0; k < 4; k++) kind_total[k] = 0;
        endfunction

        function void push_event(sbpd_pkg::event_t kind, logic [sbpd_pkg::BYTE_W-1:0] id,
                                 bit with_data);
            sbpd_pkg::result_t r;
            r.kind        = kind;
            r.pack_id     = id;
            r.error_total = err_count;
            for (int k = 0; k < sbpd_pkg::DATA_LEN; k++)
                r.data[k] = with_data ? {header_byte[k], raw[k][6:0]} : 8'h00;
            expected_q.push_back(r);
            kind_total[int'(kind)]++;
        endfunction

        function void note_word(logic [sbpd_pkg::BYTE_W-1:0] b);
            bit ok;
            if (!framing) begin
                if ({1'b0, b} < id_limit) begin
                    framing  = 1'b1;
                    tail_pos = 0;
                    id_byte  = b;
                    sum      = b[6:0];
                end else begin
                    err_count++;
                    push_event(sbpd_pkg::EV_BAD_ID, b, 1'b0);
                end
            end else if (!b[7]) begin
                framing = 1'b0;
                err_count++;
                push_event(sbpd_pkg::EV_NON_DATA, id_byte, 1'b0);
            end else if (tail_pos == sbpd_pkg::DATA_LEN + 1) begin
                ok      = (sum == b[6:0]);
                framing = 1'b0;
                if (!ok) err_count++;
                push_event(ok ? sbpd_pkg::EV_GOOD : sbpd_pkg::EV_CHECKSUM, id_byte, 1'b1);
            end else begin
                if (tail_pos == 0) header_byte = b;
                else raw[tail_pos-1] = b;
                sum = sum + b[6:0];
                tail_pos++;
            end
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            mismatches++;
            if (mismatches <= 20)
                $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
        endtask

        task check_result(sbpd_pkg::result_t got);
            sbpd_pkg::result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, pack_id", 16'(got.pack_id), '0);
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("event_kind", 16'(got.kind), 16'(want.kind));
            if (got.pack_id !== want.pack_id)
                report_mismatch("pack_id", 16'(got.pack_id), 16'(want.pack_id));
            for (int k = 0; k < sbpd_pkg::DATA_LEN; k++)
                if (got.data[k] !== want.data[k])
                    report_mismatch($sformatf("data_%0d", k), 16'(got.data[k]),
                                    16'(want.data[k]));
            if (got.error_total !== want.error_total)
                report_mismatch("error_total", 16'(got.error_total), 16'(want.error_total));
        endtask
    endclass

    logic                             aclk            = 1'b0;
    logic                             aresetn         = 1'b0;
    logic                             cfg_valid       = 1'b0;
    logic                             cfg_ready;
    logic [sbpd_pkg::ID_LIMIT_W-1:0]  cfg_max_pack_id = '0;
    logic                             s_valid         = 1'b0;
    logic                             s_ready;
    logic [sbpd_pkg::BYTE_W-1:0]      s_rx_byte       = '0;
    logic                             m_valid;
    logic                             m_ready         = 1'b0;
    logic [1:0]                       m_event_kind;
    logic [sbpd_pkg::BYTE_W-1:0]      m_pack_id;
    logic [sbpd_pkg::BYTE_W-1:0]      m_data_0, m_data_1, m_data_2, m_data_3;
    logic [sbpd_pkg::BYTE_W-1:0]      m_data_4, m_data_5, m_data_6;
    logic [sbpd_pkg::ERR_TOTAL_W-1:0] m_error_total;

    deframer_scoreboard               sb = new();
    logic [sbpd_pkg::BYTE_W-1:0]      word_plan[$];
    sbpd_pkg::result_t                seen_result;
    bit                               smooth_flow = 1'b0;
    int                               ready_hold  = 0;
    int                               cycle_count = 0;
    int                               word_total  = 0;
    int                               cfg_writes  = 0;

    seven_bit_packet_deframer_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_max_pack_id (cfg_max_pack_id),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (m_event_kind),
        .m_pack_id       (m_pack_id),
        .m_data_0        (m_data_0),
        .m_data_1        (m_data_1),
        .m_data_2        (m_data_2),
        .m_data_3        (m_data_3),
        .m_data_4        (m_data_4),
        .m_data_5        (m_data_5),
        .m_data_6        (m_data_6),
        .m_error_total   (m_error_total)
    );

    always #10 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (smooth_flow || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result-side back-pressure
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (smooth_flow || $urandom_range(0, 3) != 0) begin
            m_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
        end else begin
            m_ready    <= 1'b0;
            ready_hold <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_result.kind        = sbpd_pkg::event_t'(m_event_kind);
            seen_result.pack_id     = m_pack_id;
            seen_result.data[0]     = m_data_0;
            seen_result.data[1]     = m_data_1;
            seen_result.data[2]     = m_data_2;
            seen_result.data[3]     = m_data_3;
            seen_result.data[4]     = m_data_4;
            seen_result.data[5]     = m_data_5;
            seen_result.data[6]     = m_data_6;
            seen_result.error_total = m_error_total;
            sb.check_result(seen_result);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, sb.expected_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic drive_plan();
        logic [sbpd_pkg::BYTE_W-1:0] b;
        int gap;
        while (word_plan.size() > 0) begin
            gap = pick_gap();
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            b = word_plan.pop_front();
            s_valid   <= 1'b1;
            s_rx_byte <= b;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            sb.note_word(b);
            word_total++;
        end
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_id_limit(input logic [sbpd_pkg::ID_LIMIT_W-1:0] v);
        wait_drained();
        cfg_valid       <= 1'b1;
        cfg_max_pack_id <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid   <= 1'b0;
        sb.id_limit  = v;
        cfg_writes++;
    endtask

    // cut_at > 0 replaces that tail slot (1 header .. 9 checksum) with a non-data word
    task automatic plan_packet(input logic [sbpd_pkg::BYTE_W-1:0] id,
                               input logic [sbpd_pkg::BYTE_W-1:0] header,
                               input bit bad_sum, input int cut_at,
                               input bit rand_body, input logic [6:0] fill);
        logic [sbpd_pkg::BYTE_W-1:0] pkt [10];
        logic [6:0] total;
        int stop;
        pkt[0] = id;
        pkt[1] = header | 8'h80;
        total  = id[6:0] + pkt[1][6:0];
        for (int k = 2; k < 9; k++) begin
            pkt[k] = {1'b1, rand_body ? 7'($urandom_range(0, 127)) : fill};
            total  = total + pkt[k][6:0];
        end
        pkt[9] = {1'b1, total};
        if (bad_sum) pkt[9][6:0] = total + 7'($urandom_range(1, 127));
        if (cut_at > 0) pkt[cut_at] = 8'($urandom_range(0, 127));
        stop = (cut_at > 0) ? cut_at + 1 : 10;
        for (int k = 0; k < stop; k++) word_plan.push_back(pkt[k]);
    endtask

    task automatic plan_random(input int n);
        int lim;
        int pick;
        lim = (sb.id_limit > 256) ? 256 : int'(sb.id_limit);
        while (word_plan.size() < n) begin
            pick = $urandom_range(0, 99);
            if (lim > 0 && pick < 70)
                plan_packet(8'($urandom_range(0, lim - 1)), 8'($urandom_range(0, 255)),
                            $urandom_range(0, 3) == 0, 0, 1'b1, '0);
            else if (lim > 0 && pick < 82)
                plan_packet(8'($urandom_range(0, lim - 1)), 8'($urandom_range(0, 255)),
                            1'b0, $urandom_range(1, 9), 1'b1, '0);
            else if (pick < 92 || lim > 255)
                word_plan.push_back(8'($urandom_range(0, 255)));
            else
                word_plan.push_back(8'($urandom_range(lim, 255)));
        end
    endtask

    initial begin
        logic [sbpd_pkg::ID_LIMIT_W-1:0] limits[$];
        limits = '{9'd0, 9'd256, 9'd1, 9'd255, 9'd511, 9'd129,
                   9'($urandom_range(2, 254)), 9'd128};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset ID limit
        plan_packet(8'd0, 8'hFF, 1'b0, 0, 1'b0, 7'h00);
        plan_packet(8'd127, 8'h80, 1'b1, 0, 1'b0, 7'h7F);
        word_plan.push_back(8'd128);
        word_plan.push_back(8'd255);
        plan_packet(8'd5, 8'h80, 1'b0, 1, 1'b0, 7'h00);
        plan_packet(8'd64, 8'hA5, 1'b0, 4, 1'b1, 7'h00);
        drive_plan();

        foreach (limits[i]) begin
            set_id_limit(limits[i]);
            smooth_flow = ($urandom_range(0, 3) == 0);
            plan_random(PHASE_WORDS);
            drive_plan();
        end

        set_id_limit(9'($urandom_range(0, 511)));
        smooth_flow = 1'b0;
        plan_random(60);
        drive_plan();

        wait_drained();
        $display("%0d words over %0d ID limit settings, with gaps and result stalls",
                 word_total, cfg_writes);
        $display("events: %0d good, %0d checksum, %0d non-data, %0d bad ID",
                 sb.kind_total[int'(sbpd_pkg::EV_GOOD)],
                 sb.kind_total[int'(sbpd_pkg::EV_CHECKSUM)],
                 sb.kind_total[int'(sbpd_pkg::EV_NON_DATA)],
                 sb.kind_total[int'(sbpd_pkg::EV_BAD_ID)]);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[files.f]
sv/sbpd_pkg.sv
sv/sbpd_in_stage.sv
sv/sbpd_framer.sv
sv/sbpd_out_stage.sv
sv/seven_bit_packet_deframer_core.sv
sv/sbpd_checker.sv
tb/tb_top.sv
